// ===== rtl/core/ivc_pkg.sv =====
// Shared widths, limits and the token type that travels down the inversion counter's cell chain.
package ivc_pkg;

  localparam int VALUE_W   = 32;
  localparam int GREATER_W = 8;
  localparam int TOTAL_W   = 15;
  localparam int M_DATA_W  = 24;

  localparam logic [GREATER_W-1:0] GREATER_MAX = 8'hFF;
  localparam logic [TOTAL_W-1:0]   TOTAL_MAX   = 15'h7FFF;

  // One item in flight through the chain.
  typedef struct packed {
    logic               valid;
    logic               first;
    logic               placed;
    logic [VALUE_W-1:0] value;
  } ivc_token_t;

endpackage

// ===== rtl/core/ivc_cell.sv =====
// One cell of the chain: holds one stored value, compares it with the passing item and may store it.
module ivc_cell #(
  parameter int CW = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  ivc_pkg::ivc_token_t tok_in,
  input  logic [CW-1:0]      cnt_in,
  output ivc_pkg::ivc_token_t tok_out,
  output logic [CW-1:0]      cnt_out
);

  logic                        occ;
  logic [ivc_pkg::VALUE_W-1:0] stored;
  logic                        occ_eff;
  logic                        hit;
  logic                        take;
  ivc_pkg::ivc_token_t         tok_next;

  // A first item empties every cell it passes before it is compared there.
  assign occ_eff = occ && !(tok_in.valid && tok_in.first);
  assign hit     = tok_in.valid && occ_eff && ($signed(stored) > $signed(tok_in.value));
  assign take    = tok_in.valid && !occ_eff && !tok_in.placed;

  always_comb begin
    tok_next        = tok_in;
    tok_next.placed = tok_in.placed || take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ     <= 1'b0;
      tok_out <= '0;
    end else if (en) begin
      tok_out <= tok_next;
      if (tok_in.valid) begin
        occ <= occ_eff || take;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cnt_out <= cnt_in + CW'(hit);
      if (take) begin
        stored <= tok_in.value;
      end
    end
  end

endmodule

// ===== rtl/core/ivc_out.sv =====
// Output stage: saturates the count, keeps the running total and holds the result transaction.
module ivc_out #(
  parameter int CW = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ivc_pkg::ivc_token_t          tok,
  input  logic [CW-1:0]                cnt,
  output logic                         en,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [ivc_pkg::M_DATA_W-1:0] m_tdata,
  output logic                         m_tuser
);

  localparam int GW = (CW > ivc_pkg::GREATER_W) ? CW : ivc_pkg::GREATER_W;
  localparam int SW = ((CW > ivc_pkg::TOTAL_W) ? CW : ivc_pkg::TOTAL_W) + 1;

  logic [ivc_pkg::TOTAL_W-1:0]   total;
  logic [ivc_pkg::TOTAL_W-1:0]   total_next;
  logic [ivc_pkg::TOTAL_W-1:0]   base;
  logic [SW-1:0]                 sum;
  logic [GW-1:0]                 cnt_wide;
  logic [ivc_pkg::GREATER_W-1:0] greater;
  logic [ivc_pkg::GREATER_W-1:0] greater_out;
  logic [ivc_pkg::TOTAL_W-1:0]   total_out;
  logic                          overflow_out;

  // The whole chain moves only when the result register can take a new entry.
  assign en = !m_tvalid || m_tready;

  always_comb begin
    base     = tok.first ? '0 : total;
    sum      = SW'(base) + SW'(cnt);
    cnt_wide = GW'(cnt);
    greater  = (cnt_wide > GW'(ivc_pkg::GREATER_MAX)) ? ivc_pkg::GREATER_MAX
                                                       : cnt_wide[ivc_pkg::GREATER_W-1:0];
    // An item that found no free cell was not counted and leaves the total alone.
    if (!tok.placed) begin
      total_next = base;
    end else if (sum > SW'(ivc_pkg::TOTAL_MAX)) begin
      total_next = ivc_pkg::TOTAL_MAX;
    end else begin
      total_next = sum[ivc_pkg::TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      total    <= '0;
    end else if (en) begin
      m_tvalid <= tok.valid;
      if (tok.valid) begin
        total <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && tok.valid) begin
      greater_out  <= tok.placed ? greater : '0;
      total_out    <= total_next;
      overflow_out <= !tok.placed;
    end
  end

  assign m_tdata = {1'b0, total_out, greater_out};
  assign m_tuser = overflow_out;

endmodule

// ===== rtl/core/inversion_counter_core.sv =====
// Inversion counter top level: input stage, chain of compare-and-store cells, output stage.
//
//   channel  direction  tdata                          tuser
//   s_*      in         [31:0] value (signed)          [0] first
//   m_*      out        [7:0] greater_count,           [0] overflow
//                       [22:8] total, [23] zero
//
// One item enters per cycle while no result waits untaken; each item walks the chain one
// cell per cycle under the same condition, through every cell register and then the output register.
// Reset empties every cell and clears the running total; stored values need no clearing.
// When a result waits untaken, the whole chain and the input hold together.
module inversion_counter_core #(
  parameter int MAX_ITEMS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ivc_pkg::VALUE_W-1:0]   s_tdata,   // [31:0] value
  input  logic                          s_tuser,   // [0] first
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ivc_pkg::M_DATA_W-1:0]  m_tdata,   // [7:0] greater_count, [22:8] total
  output logic                          m_tuser    // [0] overflow
);

  localparam int CW = $clog2(MAX_ITEMS);

  ivc_pkg::ivc_token_t tok [MAX_ITEMS+1];
  logic [CW-1:0]       cnt [MAX_ITEMS+1];
  logic                en;

  assign s_tready = en;

  assign tok[0] = '{valid: s_tvalid, first: s_tuser, placed: 1'b0, value: s_tdata};
  assign cnt[0] = '0;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    ivc_cell #(
      .CW (CW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .tok_in  (tok[i]),
      .cnt_in  (cnt[i]),
      .tok_out (tok[i+1]),
      .cnt_out (cnt[i+1])
    );
  end

  ivc_out #(
    .CW (CW)
  ) u_out (
    .clk      (clk),
    .rst      (rst),
    .tok      (tok[MAX_ITEMS]),
    .cnt      (cnt[MAX_ITEMS]),
    .en       (en),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
